>>> rtl/fixed_block_pool_allocator_top_macros.svh
// Assertion macros for the block pool allocator.
// Used by fbpa_engine; no dependencies.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FBPA_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("fbpa assertion failed");
`define FBPA_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("fbpa assertion failed");
`else
`define FBPA_ASSERT(label, prop)
`define FBPA_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> rtl/fbpa_pkg.sv
// Types and constants shared by the block pool allocator.
// No dependencies.
`timescale 1ns / 1ps
package fbpa_pkg;
   localparam int MAX_BLOCKS   = 1024;
   localparam int MIN_BLOCKS   = 32;
   localparam int HEADER_BYTES = 8;
   localparam int LINK_W       = $clog2(MAX_BLOCKS);
   localparam int COUNT_W      = LINK_W + 1;
   localparam int STRIDE_W     = 17;
   localparam int LIMIT_W      = 16;
   localparam int ADDR_W       = 32;
   localparam int BYTES_W      = 16;
   localparam int PROD_W       = LINK_W + STRIDE_W;

   localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(MAX_BLOCKS);
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(64);
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(56);
   localparam logic [ADDR_W-1:0]   BASE_RESET   = '0;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_BIG  = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd3;

   localparam logic [1:0] CSR_BLOCK_COUNT   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_STRIDE  = 2'd1;
   localparam logic [1:0] CSR_PAYLOAD_LIMIT = 2'd2;
   localparam logic [1:0] CSR_BASE_ADDRESS  = 2'd3;

   typedef struct packed {
      logic               kind;
      logic [BYTES_W-1:0] request_bytes;
      logic [LINK_W-1:0]  release_index;
   } req_data_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [LINK_W-1:0]  granted_index;
      logic [ADDR_W-1:0]  payload_address;
      logic [COUNT_W-1:0] blocks_free;
   } rsp_data_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  block_count;
      logic [STRIDE_W-1:0] block_stride;
      logic [LIMIT_W-1:0]  payload_limit;
   } cfg_type;

   typedef struct packed {
      logic               granted;
      logic [1:0]         status;
      logic [LINK_W-1:0]  granted_index;
      logic [PROD_W-1:0]  offset;
      logic [COUNT_W-1:0] blocks_free;
   } eng_rsp_type;
endpackage

>>> rtl/fbpa_engine.sv
// Free-list engine: link memory, list head, counters and item sequencing.
// Depends on fbpa_pkg and fixed_block_pool_allocator_top_macros.svh.
`timescale 1ns / 1ps
`include "fixed_block_pool_allocator_top_macros.svh"
module fbpa_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  fbpa_pkg::req_data_type   req_data,
   input  fbpa_pkg::cfg_type        cfg,
   input  logic                     restart,
   input  logic [fbpa_pkg::COUNT_W-1:0] restart_count,
   output logic                     rsp_valid,
   output fbpa_pkg::eng_rsp_type    rsp
);
   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type                        state_ff;
   fbpa_pkg::req_data_type           item_ff;
   logic [fbpa_pkg::LINK_W-1:0]      head_ff;
   logic                             head_pend_ff;
   logic                             fwd_ff;
   logic [fbpa_pkg::LINK_W-1:0]      fwd_data_ff;
   logic [fbpa_pkg::LINK_W-1:0]      rdata_ff;
   logic [fbpa_pkg::COUNT_W-1:0]     free_ff;
   logic [fbpa_pkg::COUNT_W-1:0]     linked_ff;
   logic                             rsp_valid_ff;
   fbpa_pkg::eng_rsp_type            rsp_ff;
   fbpa_pkg::eng_rsp_type            rsp_in;

   logic [fbpa_pkg::LINK_W-1:0]      link_mem [fbpa_pkg::MAX_BLOCKS];

   logic [fbpa_pkg::LINK_W-1:0]      head_eff;
   logic                             exec;
   logic                             is_alloc;
   logic                             too_large;
   logic                             lazy;
   logic                             pool_full;
   logic                             pop;
   logic                             pop_more;
   logic                             bad_free;
   logic                             push;
   logic [fbpa_pkg::COUNT_W-1:0]     free_dec;
   logic [fbpa_pkg::COUNT_W-1:0]     free_inc;
   logic [fbpa_pkg::COUNT_W-1:0]     linked_inc;
   logic                             wr_en;
   logic [fbpa_pkg::LINK_W-1:0]      wr_addr;
   logic [fbpa_pkg::LINK_W-1:0]      wr_data;
   logic [fbpa_pkg::PROD_W-1:0]      offset;

   always_comb begin
      head_eff   = head_pend_ff ? (fwd_ff ? fwd_data_ff : rdata_ff) : head_ff;
      exec       = (state_ff == S_EXEC);
      is_alloc   = (item_ff.kind == fbpa_pkg::KIND_ALLOC);
      too_large  = item_ff.request_bytes > cfg.payload_limit;
      lazy       = is_alloc && !too_large && (linked_ff < cfg.block_count);
      pool_full  = (free_ff == '0);
      pop        = is_alloc && !too_large && !pool_full;
      free_dec   = free_ff - fbpa_pkg::COUNT_W'(1);
      free_inc   = free_ff + fbpa_pkg::COUNT_W'(1);
      linked_inc = linked_ff + fbpa_pkg::COUNT_W'(1);
      pop_more   = pop && (free_dec != '0);
      bad_free   = !is_alloc && ({1'b0, item_ff.release_index} >= cfg.block_count);
      push       = !is_alloc && !bad_free;
      wr_en      = exec && (lazy || push);
      wr_addr    = lazy ? linked_ff[fbpa_pkg::LINK_W-1:0] : item_ff.release_index;
      wr_data    = lazy ? linked_inc[fbpa_pkg::LINK_W-1:0] : head_eff;
      offset     = fbpa_pkg::PROD_W'(head_eff * cfg.block_stride);

      rsp_in.granted       = 1'b0;
      rsp_in.granted_index = '0;
      rsp_in.offset        = '0;
      rsp_in.blocks_free   = free_ff;
      if (!is_alloc) begin
         rsp_in.status = bad_free ? fbpa_pkg::STATUS_BAD_FREE : fbpa_pkg::STATUS_OK;
         if (push) begin
            rsp_in.blocks_free = free_inc;
         end
      end else if (too_large) begin
         rsp_in.status = fbpa_pkg::STATUS_TOO_BIG;
      end else if (pool_full) begin
         rsp_in.status = fbpa_pkg::STATUS_FULL;
      end else begin
         rsp_in.status        = fbpa_pkg::STATUS_OK;
         rsp_in.granted       = 1'b1;
         rsp_in.granted_index = head_eff;
         rsp_in.offset        = offset;
         rsp_in.blocks_free   = free_dec;
      end
   end

   // link memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= link_mem[head_eff];
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         item_ff <= req_data;
      end
      if (exec) begin
         rsp_ff      <= rsp_in;
         fwd_ff      <= lazy && (linked_ff[fbpa_pkg::LINK_W-1:0] == head_eff);
         fwd_data_ff <= linked_inc[fbpa_pkg::LINK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         head_pend_ff <= 1'b0;
         free_ff      <= fbpa_pkg::COUNT_RESET;
         linked_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (head_pend_ff) begin
            head_ff      <= head_eff;
            head_pend_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b1;
               free_ff      <= rsp_in.blocks_free;
               if (lazy) begin
                  linked_ff <= linked_inc;
               end
               if (pop_more) begin
                  head_pend_ff <= 1'b1;
               end else if (pop) begin
                  head_ff <= '0;
               end else if (push) begin
                  head_ff <= item_ff.release_index;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // restart the pool
         if (restart) begin
            head_ff      <= '0;
            head_pend_ff <= 1'b0;
            free_ff      <= restart_count;
            linked_ff    <= '0;
         end
      end
   end

   assign busy      = (state_ff == S_EXEC);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `FBPA_ASSERT_NEXT(a_exec_responds, state_ff == S_EXEC, rsp_valid_ff)
   `FBPA_ASSERT_NEXT(a_single_strobe, rsp_valid_ff, !rsp_valid_ff)
   `FBPA_ASSERT(a_pend_with_rsp, head_pend_ff |-> rsp_valid_ff && !busy)
   `FBPA_ASSERT(a_full_empty,
      rsp_valid_ff && rsp_ff.status == fbpa_pkg::STATUS_FULL |-> rsp_ff.blocks_free == '0)
endmodule

>>> rtl/fixed_block_pool_allocator_top.sv
// A command is taken at the edge where start is high and busy low; it moves the engine
// into its execute state, and its result then strobes on rsp_valid from the registered
// rsp_valid_ff. No new command is taken while busy is high, in the execute state.
// Results cannot be stalled. Reset (synchronous) restores state, counters and configuration
// to their defaults and empties the pool bookkeeping; the link memory is not cleared.
`timescale 1ns / 1ps
module fixed_block_pool_allocator_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  fbpa_pkg::req_data_type       req_data,
   output logic                         rsp_valid,
   output fbpa_pkg::rsp_data_type       rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [fbpa_pkg::ADDR_W-1:0]  csr_wdata
);
   fbpa_pkg::cfg_type                cfg_ff;
   logic [fbpa_pkg::ADDR_W-1:0]      base_ff;
   logic [fbpa_pkg::COUNT_W-1:0]     count_in;
   logic                             csr_write;
   logic                             restart;
   fbpa_pkg::eng_rsp_type            eng_rsp;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign restart   = csr_write && (csr_index == fbpa_pkg::CSR_BLOCK_COUNT);

   always_comb begin
      count_in = csr_wdata[fbpa_pkg::COUNT_W-1:0];
      if (count_in < fbpa_pkg::COUNT_W'(fbpa_pkg::MIN_BLOCKS)) begin
         count_in = fbpa_pkg::COUNT_W'(fbpa_pkg::MIN_BLOCKS);
      end else if (count_in > fbpa_pkg::COUNT_W'(fbpa_pkg::MAX_BLOCKS)) begin
         count_in = fbpa_pkg::COUNT_W'(fbpa_pkg::MAX_BLOCKS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_count   <= fbpa_pkg::COUNT_RESET;
         cfg_ff.block_stride  <= fbpa_pkg::STRIDE_RESET;
         cfg_ff.payload_limit <= fbpa_pkg::LIMIT_RESET;
         base_ff              <= fbpa_pkg::BASE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            fbpa_pkg::CSR_BLOCK_COUNT:   cfg_ff.block_count <= count_in;
            fbpa_pkg::CSR_BLOCK_STRIDE:
               cfg_ff.block_stride <= csr_wdata[fbpa_pkg::STRIDE_W-1:0];
            fbpa_pkg::CSR_PAYLOAD_LIMIT:
               cfg_ff.payload_limit <= csr_wdata[fbpa_pkg::LIMIT_W-1:0];
            fbpa_pkg::CSR_BASE_ADDRESS:  base_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   fbpa_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .cfg           (cfg_ff),
      .restart       (restart),
      .restart_count (count_in),
      .rsp_valid     (rsp_valid),
      .rsp           (eng_rsp)
   );

   always_comb begin
      rsp_data.status        = eng_rsp.status;
      rsp_data.granted_index = eng_rsp.granted_index;
      rsp_data.blocks_free   = eng_rsp.blocks_free;
      rsp_data.payload_address = '0;
      if (eng_rsp.granted) begin
         rsp_data.payload_address = base_ff
            + fbpa_pkg::ADDR_W'(eng_rsp.offset)
            + fbpa_pkg::ADDR_W'(fbpa_pkg::HEADER_BYTES);
      end
   end
endmodule
